/* src/a2i_pkg.sv */
// Shared constants, types and helper functions for the ASCII to int64 parser.
package a2i_pkg;

   // Position counter width and its saturation value
   localparam int OFFSET_BITS = 16;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Output field widths
   localparam int CH_BITS     = 8;
   localparam int VALUE_BITS  = 64;
   localparam int STATUS_BITS = 2;
   localparam int OUT_OFF_BITS = 16;
   localparam int BASE_BITS   = 6;

   // Configuration port
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   // Register addresses
   localparam logic [CSR_ADDR_BITS-1:0] REG_RADIX = 2'd0;

   // Digit value for a character that is no digit at all
   localparam logic [7:0] NO_DIGIT = 8'd255;

   // Bases handled specially
   localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

   // Characters of interest
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_NO_DIGITS = 2'd1,
      ST_RANGE     = 2'd2,
      ST_BAD_BASE  = 2'd3
   } status_type;

   // Parse phase, one-hot
   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_LEAD      = 8'b0000_0010,
      PH_SIGNED    = 8'b0000_0100,
      PH_ZERO      = 8'b0000_1000,
      PH_PREFIX    = 8'b0001_0000,
      PH_DIGITS    = 8'b0010_0000,
      PH_HOLD_OK   = 8'b0100_0000,
      PH_HOLD_NONE = 8'b1000_0000
   } phase_type;

   // Saturation limits of the magnitude
   localparam logic [VALUE_BITS-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_BITS-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

   // Digit value of a character, NO_DIGIT if not alphanumeric
   function automatic logic [7:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = NO_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_UA && c <= CH_UZ) begin
         d = c - CH_UA + 8'd10;
      end else if (c >= CH_LA && c <= CH_LZ) begin
         d = c - CH_LA + 8'd10;
      end
      return d;
   endfunction

   // White space: blank, or tab through carriage return
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // Base is automatic or 2..36
   function automatic logic base_ok(input logic [BASE_BITS-1:0] b);
      return (b == BASE_AUTO) || (b >= BASE_MIN && b <= BASE_MAX);
   endfunction

   // Saturating position increment
   function automatic logic [OFFSET_BITS-1:0] bump(input logic [OFFSET_BITS-1:0] p);
      return (p == OFFSET_MAX) ? p : p + 1'b1;
   endfunction

endpackage

/* src/ascii_to_int64_parser.sv */
// ASCII string to signed 64-bit integer parser, one character per cycle unless the NUL
// of a string waits while an earlier result is still held by rsp_tready. A result is
// registered in the result register after its terminating NUL has passed the input
// register; the per-character multiply-add by the base lies between the two registers.
// Reset: synchronous; parser goes idle, radix returns to 10, no result is pending.
module ascii_to_int64_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [a2i_pkg::CH_BITS-1:0]          req_tdata,   // [7:0] ch
   input  logic                                 req_tuser,   // [0] first
   // Result items
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [79:0]                          rsp_tdata,   // [63:0] value, [79:64] end_offset
   output logic [a2i_pkg::STATUS_BITS-1:0]      rsp_tuser,   // [1:0] status
   // Configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [a2i_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [a2i_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [a2i_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import a2i_pkg::*;

   // Configuration register
   logic [BASE_BITS-1:0] radix_ff, radix_in;
   logic                 csr_write;

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic [CH_BITS-1:0] in_ch_ff, in_ch_in;
   logic               in_first_ff, in_first_in;

   // Parse state
   phase_type              phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic                   ovf_ff, ovf_in;
   logic [BASE_BITS-1:0]   base_ff, base_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] dstart_ff, dstart_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [OUT_OFF_BITS-1:0] rsp_off_ff, rsp_off_in;

   // Step control
   logic advance;
   logic produce;
   logic load_rsp;

   // Combinational results of one character
   phase_type              nx_phase;
   logic                   nx_neg;
   logic [VALUE_BITS-1:0]  nx_mag;
   logic                   nx_ovf;
   logic [BASE_BITS-1:0]   nx_base;
   logic [OFFSET_BITS-1:0] nx_pos;
   logic [OFFSET_BITS-1:0] nx_dstart;
   logic [VALUE_BITS-1:0]  res_value;
   status_type             res_status;
   logic [OUT_OFF_BITS-1:0] res_off;
   logic                   open_string;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready &
                       (csr_paddr == REG_RADIX);
   assign radix_in   = csr_write ? csr_pwdata[BASE_BITS-1:0] : radix_ff;
   assign csr_prdata = {{(CSR_DATA_BITS-BASE_BITS){1'b0}}, radix_ff};

   // ---------------- handshake ----------------
   // An item that gives no result never waits for the result side.
   assign produce    = open_string && (in_ch_ff == CH_NUL);
   assign advance    = in_valid_ff && (!produce || !rsp_valid_ff || rsp_tready);
   assign load_rsp   = advance && produce;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign in_ch_in    = (req_tready && req_tvalid) ? req_tdata : in_ch_ff;
   assign in_first_in = (req_tready && req_tvalid) ? req_tuser : in_first_ff;

   // ---------------- one character of parsing ----------------
   always_comb begin
      phase_type              ph;
      logic                   neg;
      logic [VALUE_BITS-1:0]  mag;
      logic                   ovf;
      logic [BASE_BITS-1:0]   base;
      logic [OFFSET_BITS-1:0] pos;
      logic [OFFSET_BITS-1:0] dstart;
      logic                   done;
      logic                   take;
      logic                   from_prefix;
      phase_type              stop_ph;
      logic [7:0]             dig;
      logic [VALUE_BITS+BASE_BITS-1:0] prod;
      logic                   vbase;
      logic [32:0]            pos_wide;
      logic [VALUE_BITS-1:0]  limit;
      logic [VALUE_BITS-1:0]  mag_pre;
      logic                   ovf_pre;

      ph     = phase_ff;
      neg    = neg_ff;
      mag    = mag_ff;
      ovf    = ovf_ff;
      base   = base_ff;
      pos    = pos_ff;
      dstart = dstart_ff;
      done   = 1'b0;
      take   = 1'b0;
      from_prefix = 1'b0;
      stop_ph = PH_HOLD_OK;
      prod   = '0;

      // First character restarts the parse with the current radix
      if (in_first_ff) begin
         ph     = PH_LEAD;
         neg    = 1'b0;
         mag    = '0;
         ovf    = 1'b0;
         base   = radix_ff;
         pos    = '0;
         dstart = '0;
      end

      open_string = (ph != PH_IDLE);
      vbase       = base_ok(base);

      if (open_string && vbase && ph != PH_HOLD_OK && ph != PH_HOLD_NONE) begin
         // Leading blanks and sign
         if (ph == PH_LEAD) begin
            if (is_space(in_ch_ff)) begin
               pos  = bump(pos);
               done = 1'b1;
            end else if (in_ch_ff == CH_PLUS || in_ch_ff == CH_MINUS) begin
               neg  = (in_ch_ff == CH_MINUS);
               pos  = bump(pos);
               ph   = PH_SIGNED;
               done = 1'b1;
            end else begin
               ph = PH_SIGNED;
            end
         end
         // Leading zero may open a hex prefix
         if (!done && ph == PH_SIGNED) begin
            if (in_ch_ff == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
               pos = bump(pos);
               ph  = PH_ZERO;
            end else begin
               if (base == BASE_AUTO) begin
                  base = BASE_DEC;
               end
               take    = 1'b1;
               stop_ph = PH_HOLD_NONE;
            end
            done = 1'b1;
         end
         // After the zero: x/X or an octal/decimal digit
         if (!done && ph == PH_ZERO) begin
            if (in_ch_ff == CH_LX || in_ch_ff == CH_UX) begin
               dstart = pos;
               pos    = bump(pos);
               base   = BASE_HEX;
               ph     = PH_PREFIX;
               done   = 1'b1;
            end else begin
               if (base == BASE_AUTO) begin
                  base = BASE_OCT;
               end
               mag = '0;
               ph  = PH_DIGITS;
            end
         end
         if (!done && ph == PH_PREFIX) begin
            take        = 1'b1;
            from_prefix = 1'b1;
            done        = 1'b1;
         end
         if (!done && ph == PH_DIGITS) begin
            take = 1'b1;
         end
      end

      // A NUL is never a digit, so the result uses the magnitude from before the
      // digit step and stays off the multiplier path
      mag_pre = mag;
      ovf_pre = ovf;

      // Digit step: multiply-add with overflow on the widened product
      dig = digit_of(in_ch_ff);
      if (take) begin
         if (base < BASE_MIN || dig >= {2'b00, base}) begin
            ph = stop_ph;
            if (from_prefix) begin
               mag = '0;
               pos = dstart;
            end
         end else begin
            if (!ovf) begin
               prod = {{BASE_BITS{1'b0}}, mag} * {{VALUE_BITS{1'b0}}, base} +
                      {{(VALUE_BITS+BASE_BITS-8){1'b0}}, dig};
               if (prod[VALUE_BITS+BASE_BITS-1:VALUE_BITS] != '0) begin
                  ovf = 1'b1;
               end else begin
                  mag = prod[VALUE_BITS-1:0];
               end
            end
            pos = bump(pos);
            ph  = PH_DIGITS;
         end
      end

      // Result on the terminating NUL
      pos_wide   = 33'(pos);
      limit      = neg ? NEG_LIMIT : POS_LIMIT;
      res_value  = '0;
      res_status = ST_OK;
      res_off    = '0;
      if (!vbase) begin
         res_status = ST_BAD_BASE;
      end else if (ph == PH_HOLD_NONE) begin
         res_status = ST_NO_DIGITS;
      end else begin
         res_off = (pos_wide > 33'h0_FFFF) ? '1 : pos_wide[OUT_OFF_BITS-1:0];
         if (ovf_pre || mag_pre > limit) begin
            res_status = ST_RANGE;
            res_value  = limit;
         end else begin
            res_value = neg ? (VALUE_BITS'(0) - mag_pre) : mag_pre;
         end
      end
      if (open_string && in_ch_ff == CH_NUL) begin
         ph = PH_IDLE;
      end

      nx_phase  = ph;
      nx_neg    = neg;
      nx_mag    = mag;
      nx_ovf    = ovf;
      nx_base   = base;
      nx_pos    = pos;
      nx_dstart = dstart;
   end

   // State commits only when the item moves on
   assign phase_in  = advance ? nx_phase  : phase_ff;
   assign neg_in    = advance ? nx_neg    : neg_ff;
   assign mag_in    = advance ? nx_mag    : mag_ff;
   assign ovf_in    = advance ? nx_ovf    : ovf_ff;
   assign base_in   = advance ? nx_base   : base_ff;
   assign pos_in    = advance ? nx_pos    : pos_ff;
   assign dstart_in = advance ? nx_dstart : dstart_ff;

   // ---------------- result register ----------------
   assign rsp_valid_in  = load_rsp || (rsp_valid_ff && !rsp_tready);
   assign rsp_value_in  = load_rsp ? res_value  : rsp_value_ff;
   assign rsp_status_in = load_rsp ? res_status : rsp_status_ff;
   assign rsp_off_in    = load_rsp ? res_off    : rsp_off_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_off_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= BASE_DEC;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
         base_ff      <= '0;
         pos_ff       <= '0;
         dstart_ff    <= '0;
      end else begin
         radix_ff     <= radix_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         ovf_ff       <= ovf_in;
         base_ff      <= base_in;
         pos_ff       <= pos_in;
         dstart_ff    <= dstart_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ch_ff      <= in_ch_in;
      in_first_ff   <= in_first_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

endmodule
